[rtl/core/chte_pkg.sv]
// ----------------------------------------------------------------------------
// chte_pkg
// shared types and codes for the chained hash table engine
// ----------------------------------------------------------------------------
package chte_pkg;

    localparam int BUCKETS    = 256;
    localparam int POOL_SLOTS = 256;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_FIND  = 2'd1,
        FUNC_HEAD  = 2'd2,
        FUNC_COUNT = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_DUP    = 3'd1,
        ST_INUSE  = 3'd2,
        ST_BADIDX = 3'd3,
        ST_ABSENT = 3'd4
    } t_status;

    localparam logic [0:0] CFG_BUCKET_COUNT = 1'b0;
    localparam logic [0:0] CFG_REJECT_DUP   = 1'b1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DIV   = 10'b0000000010,
        S_START = 10'b0000000100,
        S_HEADR = 10'b0000001000,
        S_HEADW = 10'b0000010000,
        S_SREAD = 10'b0000100000,
        S_WALK  = 10'b0001000000,
        S_LINK  = 10'b0010000000,
        S_WRITE = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

endpackage

[rtl/core/chained_hash_table_engine_top.sv]
// ----------------------------------------------------------------------------
// chained_hash_table_engine_top
// hash table with separate chaining over a fixed pool of entry slots
// the key's bucket comes from a serial modulo, one quotient bit a cycle, and each
// chain link walked passes through the S_WALK and S_LINK states
// throughput: one operation at a time; stall drops once the result beat is loaded
// reset: bucket head valid, link valid and slot used bits and add count clear at once
// ----------------------------------------------------------------------------
module chained_hash_table_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_key,
    input  logic [7:0]  i_entry_slot,
    input  logic [7:0]  i_bucket_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic [7:0]  o_result_slot,
    output logic [7:0]  o_follower_count,
    output logic [2:0]  o_status,
    output logic [31:0] o_total_added,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    localparam int BW = (chte_pkg::BUCKETS > 1) ? $clog2(chte_pkg::BUCKETS) : 1;
    localparam int PW = $clog2(chte_pkg::POOL_SLOTS);
    localparam int CW = $clog2(chte_pkg::BUCKETS + 1);
    localparam int SW = $clog2(chte_pkg::POOL_SLOTS + 1);

    chte_pkg::t_state r_state, n_state;

    logic [8:0]  r_bucket_count;
    logic        r_reject_dup;

    logic [BW-1:0] r_head [chte_pkg::BUCKETS];
    logic [chte_pkg::BUCKETS-1:0] r_head_vld;
    logic [PW-1:0] r_link [chte_pkg::POOL_SLOTS];
    logic [chte_pkg::POOL_SLOTS-1:0] r_link_vld;
    logic [31:0]   r_ekey [chte_pkg::POOL_SLOTS];
    logic [chte_pkg::POOL_SLOTS-1:0] r_used;
    logic [31:0]   r_adds;

    logic [1:0]  r_func;
    logic [31:0] r_key;
    logic [7:0]  r_slot;
    logic [7:0]  r_bidx;
    logic [CW-1:0] r_nb;
    logic [31:0] r_rem;
    logic [5:0]  r_cnt;
    logic [BW-1:0] r_bkt;
    logic [PW-1:0] r_cur;
    logic        r_cvld;
    logic [SW-1:0] r_steps;
    logic [7:0]  r_fcnt;
    logic [PW-1:0] r_hd;
    logic        r_hdv;
    logic [31:0] r_rdkey;
    logic [PW-1:0] r_rdlink;
    logic        r_rdlv;
    logic        r_slot_used;
    logic        r_found;
    logic [7:0]  r_rslot;
    logic [2:0]  r_status;
    logic        r_ovld;

    logic        w_acc;
    logic [8:0]  w_nb9;
    logic [32:0] w_trial;
    logic        w_slot_ok;

    assign w_acc = i_valid && !o_stall;
    assign o_stall = (r_state != chte_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == chte_pkg::S_IDLE) && !r_ovld;
    assign w_nb9 = (r_bucket_count == 9'd0) ? 9'd1 :
                   ((32'(r_bucket_count) > chte_pkg::BUCKETS) ? 9'(chte_pkg::BUCKETS)
                                                              : r_bucket_count);
    assign w_trial = {r_rem[30:0], r_key[5'(31 - r_cnt)]} - 33'(r_nb);
    assign w_slot_ok = 32'(r_slot) < chte_pkg::POOL_SLOTS;

    always_comb begin
        n_state = r_state;
        case (r_state)
            chte_pkg::S_IDLE:  if (w_acc) n_state = chte_pkg::S_DIV;
            chte_pkg::S_DIV:   if (r_cnt == 6'd31) n_state = chte_pkg::S_START;
            chte_pkg::S_START: begin
                n_state = chte_pkg::S_HEADR;
                case (r_func)
                    chte_pkg::FUNC_ADD: begin
                        if (!w_slot_ok || r_slot_used) n_state = chte_pkg::S_OUT;
                    end
                    chte_pkg::FUNC_HEAD: begin
                        if (9'(r_bidx) >= 9'(r_nb)) n_state = chte_pkg::S_OUT;
                    end
                    chte_pkg::FUNC_COUNT: begin
                        if (!w_slot_ok || !r_slot_used) n_state = chte_pkg::S_OUT;
                        else n_state = chte_pkg::S_SREAD;
                    end
                    default: ;
                endcase
            end
            chte_pkg::S_HEADR: n_state = chte_pkg::S_HEADW;
            chte_pkg::S_HEADW: begin
                if (r_func == chte_pkg::FUNC_HEAD) n_state = chte_pkg::S_OUT;
                else if (r_func == chte_pkg::FUNC_ADD && !r_reject_dup)
                    n_state = chte_pkg::S_WRITE;
                else n_state = chte_pkg::S_WALK;
            end
            chte_pkg::S_SREAD: n_state = chte_pkg::S_WALK;
            chte_pkg::S_WALK: begin
                n_state = chte_pkg::S_LINK;
                // first visit of a follower count is the given entry itself
                if (!(r_func == chte_pkg::FUNC_COUNT && r_steps == '0)
                        && (!r_cvld || r_steps > SW'(chte_pkg::POOL_SLOTS))) begin
                    n_state = (r_func == chte_pkg::FUNC_ADD) ? chte_pkg::S_WRITE
                                                             : chte_pkg::S_OUT;
                end
            end
            chte_pkg::S_LINK: begin
                n_state = chte_pkg::S_WALK;
                if (r_func != chte_pkg::FUNC_COUNT && r_rdkey == r_key) begin
                    n_state = (r_func == chte_pkg::FUNC_ADD) ? chte_pkg::S_WRITE
                                                             : chte_pkg::S_OUT;
                end
            end
            chte_pkg::S_WRITE: n_state = chte_pkg::S_OUT;
            chte_pkg::S_OUT:   if (!(r_ovld && i_stall)) n_state = chte_pkg::S_IDLE;
            default:           n_state = chte_pkg::S_IDLE;
        endcase
    end

    // memories: registered reads
    always_ff @(posedge i_clk) begin
        r_rdkey  <= r_ekey[r_cur];
        r_rdlink <= r_link[r_cur];
        r_hd     <= r_head[r_bkt];
        if (r_state == chte_pkg::S_WRITE && r_func == chte_pkg::FUNC_ADD
                && r_status == chte_pkg::ST_OK) begin
            r_ekey[r_slot[PW-1:0]] <= r_key;
            r_link[r_slot[PW-1:0]] <= r_hd;
            r_head[r_bkt] <= r_slot[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= chte_pkg::S_IDLE;
            r_bucket_count <= 9'd256;
            r_reject_dup   <= 1'b0;
            r_head_vld     <= '0;
            r_used         <= '0;
            r_link_vld     <= '0;
            r_adds         <= '0;
            r_ovld         <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == chte_pkg::S_OUT && !(r_ovld && i_stall)) r_ovld <= 1'b1;
            else if (r_ovld && !i_stall) r_ovld <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == chte_pkg::CFG_BUCKET_COUNT) r_bucket_count <= i_cfg_data;
                else r_reject_dup <= i_cfg_data[0];
            end
            case (r_state)
                chte_pkg::S_IDLE: if (w_acc) begin
                    r_func <= i_func; r_key <= i_key;
                    r_slot <= i_entry_slot; r_bidx <= i_bucket_index;
                    r_nb <= CW'(w_nb9); r_rem <= '0; r_cnt <= '0;
                    r_found <= 1'b0; r_rslot <= '0; r_fcnt <= '0;
                    r_status <= chte_pkg::ST_OK; r_steps <= '0;
                end
                chte_pkg::S_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    r_slot_used <= r_used[r_slot[PW-1:0]];
                    if (!w_trial[32]) r_rem <= w_trial[31:0];
                    else r_rem <= {r_rem[30:0], r_key[5'(31 - r_cnt)]};
                end
                chte_pkg::S_START: begin
                    r_bkt <= (r_func == chte_pkg::FUNC_HEAD) ? BW'(r_bidx) : BW'(r_rem);
                    r_cvld <= 1'b0;
                    case (r_func)
                        chte_pkg::FUNC_ADD: begin
                            if (!w_slot_ok) r_status <= chte_pkg::ST_BADIDX;
                            else if (r_slot_used) r_status <= chte_pkg::ST_INUSE;
                        end
                        chte_pkg::FUNC_HEAD: begin
                            if (9'(r_bidx) >= 9'(r_nb)) r_status <= chte_pkg::ST_BADIDX;
                        end
                        chte_pkg::FUNC_COUNT: begin
                            r_cur <= r_slot[PW-1:0];
                            if (!w_slot_ok) r_status <= chte_pkg::ST_BADIDX;
                            else if (!r_slot_used) r_status <= chte_pkg::ST_ABSENT;
                        end
                        default: ;
                    endcase
                end
                chte_pkg::S_HEADR: r_hdv <= r_head_vld[r_bkt];
                chte_pkg::S_HEADW: begin
                    r_cur  <= r_hd;
                    r_cvld <= r_hdv;
                    if (r_func == chte_pkg::FUNC_HEAD) begin
                        r_found <= r_hdv;
                        r_rslot <= r_hdv ? 8'(r_hd) : 8'd0;
                    end
                end
                chte_pkg::S_SREAD: r_cvld <= 1'b1;
                chte_pkg::S_WALK: r_rdlv <= r_link_vld[r_cur];
                chte_pkg::S_LINK: begin
                    r_steps <= r_steps + SW'(1);
                    r_cur  <= r_rdlink;
                    r_cvld <= r_rdlv;
                    if (r_func == chte_pkg::FUNC_COUNT) begin
                        if (r_steps != '0 && r_fcnt != 8'd255) r_fcnt <= r_fcnt + 8'd1;
                    end else if (r_rdkey == r_key) begin
                        r_found <= 1'b1;
                        r_rslot <= 8'(r_cur);
                        if (r_func == chte_pkg::FUNC_ADD) r_status <= chte_pkg::ST_DUP;
                    end
                end
                chte_pkg::S_WRITE: begin
                    if (r_status == chte_pkg::ST_OK) begin
                        r_link_vld[r_slot[PW-1:0]] <= r_hdv;
                        r_head_vld[r_bkt] <= 1'b1;
                        r_used[r_slot[PW-1:0]] <= 1'b1;
                        r_adds <= r_adds + 32'd1;
                    end
                end
                chte_pkg::S_OUT: begin
                    if (!(r_ovld && i_stall)) begin
                        o_found <= r_found; o_result_slot <= r_rslot;
                        o_follower_count <= r_fcnt; o_status <= r_status;
                        o_total_added <= r_adds;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_ovld;

endmodule
